### design/gal_pkg.sv
// ----------------------------------------------------------------------------
// gal_pkg
// Shared types, constants and the control store of the grid atlas layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package gal_pkg;

  localparam int unsigned MAX_IMAGES_DEF = 64;
  localparam int unsigned DIM_BITS_DEF   = 12;

  localparam int unsigned IMG_DIM_W = 12;
  localparam int unsigned PAD_W     = 8;
  localparam int unsigned POS_W     = 19;
  localparam int unsigned GRID_W    = 7;
  localparam int unsigned ATLAS_W   = 18;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD      = 3'd0;
  localparam step_t STEP_RHS       = 3'd1;
  localparam step_t STEP_SEARCH    = 3'd2;
  localparam step_t STEP_ROWS_INIT = 3'd3;
  localparam step_t STEP_ROWS      = 3'd4;
  localparam step_t STEP_AW        = 3'd5;
  localparam step_t STEP_AH        = 3'd6;
  localparam step_t STEP_EMIT      = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_INIT,
    OP_SRCH,
    OP_ROWS_INIT,
    OP_ROWS,
    OP_EMIT_INIT,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    A_COUNT,
    A_COLS,
    A_ROWS
  } a_sel_e;

  typedef enum logic {
    B_CELL_W,
    B_CELL_H
  } b_sel_e;

  typedef enum logic [1:0] {
    MD_NONE,
    MD_RHS,
    MD_AW,
    MD_AH
  } mul_dst_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LAST_IN,
    C_W_ZERO,
    C_SRCH_DONE,
    C_ROWS_DONE,
    C_EMIT_LAST
  } cond_e;

  typedef struct packed {
    logic     in_ready;
    op_e      op;
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    mul_dst_e mul_dst;
    cond_e    cond;
    step_t    jump;
    logic     adv;
  } ctrl_t;

  typedef struct packed {
    logic last_in;
    logic w_zero;
    logic srch_done;
    logic rows_done;
    logic emit_last;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = '{in_ready: 1'b0, op: OP_NONE, a_sel: A_COUNT, b_sel: B_CELL_W,
           mul_dst: MD_NONE, cond: C_NEVER, jump: STEP_LOAD, adv: 1'b0};
    case (step)
      STEP_LOAD: begin
        cw.in_ready = 1'b1;
        cw.op       = OP_LOAD;
        cw.cond     = C_LAST_IN;
        cw.jump     = STEP_RHS;
      end
      STEP_RHS: begin
        cw.op      = OP_SRCH_INIT;
        cw.a_sel   = A_COUNT;
        cw.b_sel   = B_CELL_H;
        cw.mul_dst = MD_RHS;
        cw.cond    = C_W_ZERO;
        cw.jump    = STEP_ROWS_INIT;
        cw.adv     = 1'b1;
      end
      STEP_SEARCH: begin
        cw.op   = OP_SRCH;
        cw.cond = C_SRCH_DONE;
        cw.jump = STEP_ROWS_INIT;
      end
      STEP_ROWS_INIT: begin
        cw.op   = OP_ROWS_INIT;
        cw.cond = C_ALWAYS;
        cw.jump = STEP_ROWS;
      end
      STEP_ROWS: begin
        cw.op   = OP_ROWS;
        cw.cond = C_ROWS_DONE;
        cw.jump = STEP_AW;
      end
      STEP_AW: begin
        cw.a_sel   = A_COLS;
        cw.b_sel   = B_CELL_W;
        cw.mul_dst = MD_AW;
        cw.cond    = C_ALWAYS;
        cw.jump    = STEP_AH;
      end
      STEP_AH: begin
        cw.op      = OP_EMIT_INIT;
        cw.a_sel   = A_ROWS;
        cw.b_sel   = B_CELL_H;
        cw.mul_dst = MD_AH;
        cw.cond    = C_ALWAYS;
        cw.jump    = STEP_EMIT;
      end
      STEP_EMIT: begin
        cw.op   = OP_EMIT;
        cw.cond = C_EMIT_LAST;
        cw.jump = STEP_LOAD;
      end
      default: begin
        cw.cond = C_ALWAYS;
        cw.jump = STEP_LOAD;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

### design/gal_seq.sv
// ----------------------------------------------------------------------------
// gal_seq
// Step counter and control store; picks the next step from datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module gal_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire gal_pkg::status_t status_i,
  output gal_pkg::ctrl_t        ctrl_o
);

  gal_pkg::step_t step_q;
  gal_pkg::step_t step_d;
  gal_pkg::ctrl_t cw;
  logic           take_jump;

  assign cw     = gal_pkg::ucode(step_q);
  assign ctrl_o = cw;

  always_comb begin
    case (cw.cond)
      gal_pkg::C_NEVER:     take_jump = 1'b0;
      gal_pkg::C_ALWAYS:    take_jump = 1'b1;
      gal_pkg::C_LAST_IN:   take_jump = status_i.last_in;
      gal_pkg::C_W_ZERO:    take_jump = status_i.w_zero;
      gal_pkg::C_SRCH_DONE: take_jump = status_i.srch_done;
      gal_pkg::C_ROWS_DONE: take_jump = status_i.rows_done;
      gal_pkg::C_EMIT_LAST: take_jump = status_i.emit_last;
      default:              take_jump = 1'b0;
    endcase
  end

  always_comb begin
    if (take_jump) begin
      step_d = cw.jump;
    end else if (cw.adv) begin
      step_d = step_q + gal_pkg::step_t'(1);
    end else begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gal_pkg::STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

### design/gal_dp.sv
// ----------------------------------------------------------------------------
// gal_dp
// Datapath: cell size, image count, padding store, shared multiplier,
// column and row search registers, position walk and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gal_dp #(
  parameter int unsigned MAX_IMAGES = gal_pkg::MAX_IMAGES_DEF,
  parameter int unsigned DIM_BITS   = gal_pkg::DIM_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gal_pkg::ctrl_t                ctrl_i,
  output gal_pkg::status_t                   status_o,
  input  wire logic                          in_valid_i,
  input  wire logic [gal_pkg::IMG_DIM_W-1:0] img_width_i,
  input  wire logic [gal_pkg::IMG_DIM_W-1:0] img_height_i,
  input  wire logic [gal_pkg::PAD_W-1:0]     pad_i,
  input  wire logic                          last_image_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gal_pkg::POS_W-1:0]          pos_x_o,
  output logic [gal_pkg::POS_W-1:0]          pos_y_o,
  output logic [gal_pkg::GRID_W-1:0]         grid_columns_o,
  output logic [gal_pkg::GRID_W-1:0]         grid_rows_o,
  output logic [gal_pkg::ATLAS_W-1:0]        atlas_width_o,
  output logic [gal_pkg::ATLAS_W-1:0]        atlas_height_o,
  output logic                               last_pos_o
);

  localparam int unsigned CntW = $clog2(MAX_IMAGES + 1);
  localparam int unsigned IdxW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int unsigned InW  = (DIM_BITS < gal_pkg::IMG_DIM_W) ? DIM_BITS
                                                                 : gal_pkg::IMG_DIM_W;
  localparam int unsigned PW   = CntW + DIM_BITS;
  localparam int unsigned LW   = DIM_BITS + 2 * CntW + 1;
  localparam int unsigned AccW = CntW + 1;
  localparam int unsigned PosW = gal_pkg::POS_W;
  localparam int unsigned AtW  = gal_pkg::ATLAS_W;
  localparam int unsigned GrW  = gal_pkg::GRID_W;

  logic [DIM_BITS-1:0] cell_w_q, cell_w_d;
  logic [DIM_BITS-1:0] cell_h_q, cell_h_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     cols_q, cols_d;
  logic [CntW-1:0]     rows_q, rows_d;
  logic [LW-1:0]       lhs_q, lhs_d;
  logic [LW-1:0]       inc_q, inc_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [PW-1:0]       rhs_q;
  logic [AtW-1:0]      aw_q, ah_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [PosW-1:0]     xoff_q, xoff_d;
  logic [PosW-1:0]     yoff_q, yoff_d;

  logic [gal_pkg::PAD_W-1:0] pad_mem [MAX_IMAGES];
  logic [gal_pkg::PAD_W-1:0] pad_rd_q;

  logic                out_valid_q;
  logic [PosW-1:0]     pos_x_q, pos_y_q;
  logic [GrW-1:0]      cols_out_q, rows_out_q;
  logic [AtW-1:0]      aw_out_q, ah_out_q;
  logic                last_out_q;

  logic [DIM_BITS-1:0] w_in, h_in;
  logic                in_acc, not_full, store_en;
  logic [CntW-1:0]     mul_a;
  logic [DIM_BITS-1:0] mul_b;
  logic [PW-1:0]       prod;
  logic                srch_done, rows_done, w_zero;
  logic                emit_go, is_last, emit_last;
  logic [PosW-1:0]     pos_x_d, pos_y_d;

  assign w_in     = DIM_BITS'(img_width_i[InW-1:0]);
  assign h_in     = DIM_BITS'(img_height_i[InW-1:0]);
  assign in_acc   = in_valid_i && ctrl_i.in_ready;
  assign not_full = (count_q != CntW'(MAX_IMAGES));
  assign store_en = (ctrl_i.op == gal_pkg::OP_LOAD) && in_acc && not_full;

  assign w_zero    = (cell_w_q == '0);
  assign srch_done = (lhs_q >= LW'(rhs_q)) || (cols_q == CntW'(MAX_IMAGES));
  assign rows_done = (acc_q >= AccW'(count_q));
  assign is_last   = (CntW'(idx_q) == (count_q - CntW'(1)));
  assign emit_go   = (ctrl_i.op == gal_pkg::OP_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last = emit_go && is_last;

  assign status_o = '{last_in:   in_acc && last_image_i,
                      w_zero:    w_zero,
                      srch_done: srch_done,
                      rows_done: rows_done,
                      emit_last: emit_last};

  // shared multiplier
  always_comb begin
    case (ctrl_i.a_sel)
      gal_pkg::A_COUNT: mul_a = count_q;
      gal_pkg::A_COLS:  mul_a = cols_q;
      gal_pkg::A_ROWS:  mul_a = rows_q;
      default:          mul_a = count_q;
    endcase
    case (ctrl_i.b_sel)
      gal_pkg::B_CELL_W: mul_b = cell_w_q;
      gal_pkg::B_CELL_H: mul_b = cell_h_q;
      default:           mul_b = cell_w_q;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.mul_dst)
      gal_pkg::MD_RHS: rhs_q <= prod;
      gal_pkg::MD_AW:  aw_q  <= AtW'(prod);
      gal_pkg::MD_AH:  ah_q  <= AtW'(prod);
      default: begin
      end
    endcase
  end

  assign pos_x_d = xoff_q + PosW'(pad_rd_q);
  assign pos_y_d = yoff_q + PosW'(pad_rd_q);

  always_comb begin
    cell_w_d = cell_w_q;
    cell_h_d = cell_h_q;
    count_d  = count_q;
    cols_d   = cols_q;
    rows_d   = rows_q;
    lhs_d    = lhs_q;
    inc_d    = inc_q;
    acc_d    = acc_q;
    idx_d    = idx_q;
    col_d    = col_q;
    xoff_d   = xoff_q;
    yoff_d   = yoff_q;
    case (ctrl_i.op)
      gal_pkg::OP_LOAD: begin
        if (store_en) begin
          if (w_in > cell_w_q) begin
            cell_w_d = w_in;
          end
          if (h_in > cell_h_q) begin
            cell_h_d = h_in;
          end
          count_d = count_q + CntW'(1);
        end
      end
      gal_pkg::OP_SRCH_INIT: begin
        cols_d = w_zero ? count_q : CntW'(1);
        lhs_d  = LW'(cell_w_q);
        inc_d  = LW'({cell_w_q, 1'b0}) + LW'(cell_w_q);
      end
      gal_pkg::OP_SRCH: begin
        if (!srch_done) begin
          cols_d = cols_q + CntW'(1);
          lhs_d  = lhs_q + inc_q;
          inc_d  = inc_q + LW'({cell_w_q, 1'b0});
        end
      end
      gal_pkg::OP_ROWS_INIT: begin
        rows_d = CntW'(1);
        acc_d  = AccW'(cols_q);
      end
      gal_pkg::OP_ROWS: begin
        if (!rows_done) begin
          rows_d = rows_q + CntW'(1);
          acc_d  = acc_q + AccW'(cols_q);
        end
      end
      gal_pkg::OP_EMIT_INIT: begin
        idx_d  = '0;
        col_d  = '0;
        xoff_d = '0;
        yoff_d = '0;
      end
      gal_pkg::OP_EMIT: begin
        if (emit_go) begin
          idx_d = idx_q + IdxW'(1);
          if (col_q == (cols_q - CntW'(1))) begin
            col_d  = '0;
            xoff_d = '0;
            yoff_d = yoff_q + PosW'(cell_h_q);
          end else begin
            col_d  = col_q + CntW'(1);
            xoff_d = xoff_q + PosW'(cell_w_q);
          end
          if (is_last) begin
            cell_w_d = '0;
            cell_h_d = '0;
            count_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q    <= '0;
      cell_h_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cell_w_q <= cell_w_d;
      cell_h_q <= cell_h_d;
      count_q  <= count_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cols_q <= cols_d;
    rows_q <= rows_d;
    lhs_q  <= lhs_d;
    inc_q  <= inc_d;
    acc_q  <= acc_d;
    idx_q  <= idx_d;
    col_q  <= col_d;
    xoff_q <= xoff_d;
    yoff_q <= yoff_d;
  end

  // padding store
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      pad_mem[count_q[IdxW-1:0]] <= pad_i;
    end
    pad_rd_q <= pad_mem[idx_d];
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      cols_out_q <= GrW'(cols_q);
      rows_out_q <= GrW'(rows_q);
      aw_out_q   <= aw_q;
      ah_out_q   <= ah_q;
      last_out_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign grid_columns_o = cols_out_q;
  assign grid_rows_o    = rows_out_q;
  assign atlas_width_o  = aw_out_q;
  assign atlas_height_o = ah_out_q;
  assign last_pos_o     = last_out_q;

endmodule

`default_nettype wire

### design/grid_atlas_layout_top.sv
// ----------------------------------------------------------------------------
// grid_atlas_layout_top
// Uniform grid atlas layout: collects image sizes and paddings, then emits
// one atlas position per image in row-major order.
// One input beat per cycle while loading; after the last beat, the column
// search and row count run on the shared multiplier and adder loops, then
// one output beat per cycle while the receiver takes them from the output
// register. Reset is asynchronous: it clears the step counter, cell size,
// image count and output valid; paddings are not.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_atlas_layout_top #(
  parameter int unsigned MAX_IMAGES = gal_pkg::MAX_IMAGES_DEF,
  parameter int unsigned DIM_BITS   = gal_pkg::DIM_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [gal_pkg::IMG_DIM_W-1:0] img_width_i,
  input  wire logic [gal_pkg::IMG_DIM_W-1:0] img_height_i,
  input  wire logic [gal_pkg::PAD_W-1:0]     pad_i,
  input  wire logic                          last_image_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gal_pkg::POS_W-1:0]          pos_x_o,
  output logic [gal_pkg::POS_W-1:0]          pos_y_o,
  output logic [gal_pkg::GRID_W-1:0]         grid_columns_o,
  output logic [gal_pkg::GRID_W-1:0]         grid_rows_o,
  output logic [gal_pkg::ATLAS_W-1:0]        atlas_width_o,
  output logic [gal_pkg::ATLAS_W-1:0]        atlas_height_o,
  output logic                               last_pos_o
);

  gal_pkg::ctrl_t   ctrl;
  gal_pkg::status_t status;

  assign in_ready_o = ctrl.in_ready;

  gal_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  gal_dp #(
    .MAX_IMAGES (MAX_IMAGES),
    .DIM_BITS   (DIM_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .img_width_i    (img_width_i),
    .img_height_i   (img_height_i),
    .pad_i          (pad_i),
    .last_image_i   (last_image_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .grid_columns_o (grid_columns_o),
    .grid_rows_o    (grid_rows_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .last_pos_o     (last_pos_o)
  );

endmodule

`default_nettype wire

### test/tb_grid_atlas_layout_top.sv
// ----------------------------------------------------------------------------
// tb_grid_atlas_layout_top
// Self-checking bench for the grid atlas layout block. Image beats go in as
// sets closed by a last beat; a scoreboard tracks cell size, image count and
// paddings and predicts the row-major position beats of each set, including
// all-zero widths, zero heights, column saturation and sets that overflow.
// Both handshakes idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grid_atlas_layout_top;

  localparam int unsigned IMG_DIM_W      = gal_pkg::IMG_DIM_W;
  localparam int unsigned PAD_W          = gal_pkg::PAD_W;
  localparam int unsigned POS_W          = gal_pkg::POS_W;
  localparam int unsigned GRID_W         = gal_pkg::GRID_W;
  localparam int unsigned ATLAS_W        = gal_pkg::ATLAS_W;
  localparam int unsigned MAX_IMAGES_DEF = gal_pkg::MAX_IMAGES_DEF;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 180;

  typedef struct {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [GRID_W-1:0]  columns;
    logic [GRID_W-1:0]  rows;
    logic [ATLAS_W-1:0] atlas_w;
    logic [ATLAS_W-1:0] atlas_h;
    logic               last;
  } position_t;

  class layout_scoreboard;
    logic [IMG_DIM_W-1:0] cell_w;
    logic [IMG_DIM_W-1:0] cell_h;
    int unsigned          count;
    logic [PAD_W-1:0]     pads [MAX_IMAGES_DEF];
    position_t            pending [$];
    int unsigned          errors;
    int unsigned          images;
    int unsigned          dropped;
    int unsigned          sets;
    int unsigned          positions;

    function new();
      cell_w    = '0;
      cell_h    = '0;
      count     = 0;
      errors    = 0;
      images    = 0;
      dropped   = 0;
      sets      = 0;
      positions = 0;
    endfunction

    function void note_image(input logic [IMG_DIM_W-1:0] w, input logic [IMG_DIM_W-1:0] h,
                             input logic [PAD_W-1:0] p, input logic last);
      int unsigned       n;
      int unsigned       cols;
      int unsigned       rows;
      longint unsigned   need;
      longint unsigned   cc;
      position_t         beat;
      images++;
      if (count < MAX_IMAGES_DEF) begin
        if (w > cell_w) cell_w = w;
        if (h > cell_h) cell_h = h;
        pads[count] = p;
        count++;
      end else begin
        dropped++;
      end
      if (!last) return;
      n = count;
      if (cell_w == 0) begin
        cols = n;
      end else begin
        need = longint'(cell_h) * n;
        cols = MAX_IMAGES_DEF;
        for (int c = MAX_IMAGES_DEF; c >= 1; c--) begin
          cc = c;
          if (cc * cc * cell_w >= need) cols = c;
        end
      end
      rows = (n + cols - 1) / cols;
      for (int unsigned i = 0; i < n; i++) begin
        beat.pos_x   = POS_W'((i % cols) * cell_w + pads[i]);
        beat.pos_y   = POS_W'((i / cols) * cell_h + pads[i]);
        beat.columns = GRID_W'(cols);
        beat.rows    = GRID_W'(rows);
        beat.atlas_w = ATLAS_W'(cols * cell_w);
        beat.atlas_h = ATLAS_W'(rows * cell_h);
        beat.last    = (i + 1 == n);
        pending.push_back(beat);
      end
      sets++;
      cell_w = '0;
      cell_h = '0;
      count  = 0;
    endfunction

    function void compare(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_position(input position_t got);
      position_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected position beat, expected none actual x=%0d y=%0d",
                 $time, got.pos_x, got.pos_y);
        return;
      end
      want = pending.pop_front();
      positions++;
      compare("pos_x", want.pos_x, got.pos_x);
      compare("pos_y", want.pos_y, got.pos_y);
      compare("grid_columns", want.columns, got.columns);
      compare("grid_rows", want.rows, got.rows);
      compare("atlas_width", want.atlas_w, got.atlas_w);
      compare("atlas_height", want.atlas_h, got.atlas_h);
      compare("last_pos", want.last, got.last);
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [IMG_DIM_W-1:0] img_width_i  = '0;
  logic [IMG_DIM_W-1:0] img_height_i = '0;
  logic [PAD_W-1:0]     pad_i        = '0;
  logic                 last_image_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [POS_W-1:0]     pos_x_o;
  logic [POS_W-1:0]     pos_y_o;
  logic [GRID_W-1:0]    grid_columns_o;
  logic [GRID_W-1:0]    grid_rows_o;
  logic [ATLAS_W-1:0]   atlas_width_o;
  logic [ATLAS_W-1:0]   atlas_height_o;
  logic                 last_pos_o;

  layout_scoreboard sb = new();
  bit               calm     = 1'b0;
  bit               hold_req = 1'b0;
  int unsigned      cycle_count = 0;

  grid_atlas_layout_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .img_width_i    (img_width_i),
    .img_height_i   (img_height_i),
    .pad_i          (pad_i),
    .last_image_i   (last_image_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .grid_columns_o (grid_columns_o),
    .grid_rows_o    (grid_rows_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .last_pos_o     (last_pos_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [IMG_DIM_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 40) return IMG_DIM_W'($urandom_range(1, 64));
    if (r < 50) return '1;
    return IMG_DIM_W'($urandom_range(4095));
  endfunction

  task automatic send_image(input logic [IMG_DIM_W-1:0] w, input logic [IMG_DIM_W-1:0] h,
                            input logic [PAD_W-1:0] p, input logic last);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    img_width_i  <= w;
    img_height_i <= h;
    pad_i        <= p;
    last_image_i <= last;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_image(w, h, p, last);
  endtask

  task automatic send_set(input int unsigned n);
    int unsigned          style;
    logic [IMG_DIM_W-1:0] w;
    logic [IMG_DIM_W-1:0] h;
    style = $urandom_range(19);
    for (int unsigned k = 0; k < n; k++) begin
      w = rand_dim();
      h = rand_dim();
      if (style == 0) w = '0;
      if (style == 1) h = '0;
      if (style == 2) begin
        w = IMG_DIM_W'($urandom_range(0, 3));
        h = IMG_DIM_W'($urandom_range(3000, 4095));
      end
      send_image(w, h, PAD_W'($urandom_range(255)), k == n - 1);
    end
  endtask

  initial begin : receive_side
    int unsigned hold_cycles;
    position_t   got;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold_cycles++;
        end
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 21);
        @(negedge clk_i);
        if (out_valid_o && out_ready_i) begin
          got.pos_x   = pos_x_o;
          got.pos_y   = pos_y_o;
          got.columns = grid_columns_o;
          got.rows    = grid_rows_o;
          got.atlas_w = atlas_width_o;
          got.atlas_h = atlas_height_o;
          got.last    = last_pos_o;
          sb.check_position(got);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d position beats outstanding", $time, sb.pending.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : send_side
    int unsigned random_items;
    int unsigned r;
    int unsigned n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single images at the extremes
    send_image(12'd0, 12'd0, 8'd0, 1'b1);
    send_image(12'd4095, 12'd4095, 8'd255, 1'b1);
    // all widths zero
    send_image(12'd0, 12'd100, 8'd1, 1'b0);
    send_image(12'd0, 12'd4095, 8'd2, 1'b0);
    send_image(12'd0, 12'd7, 8'd3, 1'b1);
    // zero height
    send_image(12'd10, 12'd0, 8'd0, 1'b0);
    send_image(12'd4095, 12'd0, 8'd255, 1'b0);
    send_image(12'd1, 12'd0, 8'd9, 1'b1);
    // column search saturates
    send_image(12'd1, 12'd4095, 8'd5, 1'b0);
    send_image(12'd0, 12'd4095, 8'd6, 1'b1);
    // mixed bit patterns
    send_image(12'd2730, 12'd1365, 8'd170, 1'b0);
    send_image(12'd1365, 12'd2730, 8'd85, 1'b0);
    send_image(12'd100, 12'd200, 8'd0, 1'b0);
    send_image(12'd37, 12'd4000, 8'd200, 1'b0);
    send_image(12'd4095, 12'd1, 8'd255, 1'b1);

    hold_req = 1'b1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80) n = $urandom_range(1, 12);
      else if (r < 90) n = $urandom_range(13, MAX_IMAGES_DEF);
      else n = $urandom_range(MAX_IMAGES_DEF + 1, MAX_IMAGES_DEF + 4);
      calm = (random_items >= 60 && random_items < 110);
      send_set(n);
      random_items += n;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d image beats in %0d sets (%0d dropped on full sets), %0d positions checked",
             sb.images, sb.sets, sb.dropped, sb.positions);
    $display("%0d mismatches over %0d cycles", sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/gal_pkg.sv
design/gal_seq.sv
design/gal_dp.sv
design/grid_atlas_layout_top.sv
test/tb_grid_atlas_layout_top.sv
